[rtl/core/mpt_pkg.sv]
// mpt_pkg: shared types, constants and helpers of the mouse pointer tracker
`timescale 1ns / 1ps
package mpt_pkg;

	localparam int unsigned POS_W   = 12;
	localparam int unsigned EDGE_W  = 13;
	localparam int unsigned DELTA_W = 12;
	localparam int unsigned GAIN_W  = 18;
	localparam int unsigned PROD_W  = 30;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned SUM_W   = 15;
	localparam int unsigned STEP_W  = 14;
	localparam int unsigned MOVE_W  = 13;
	localparam int unsigned BTN_W   = 6;
	localparam int unsigned TICK_W  = 32;
	localparam int unsigned DELAY_W = 16;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned CDATA_W = 16;
	localparam int unsigned IN_W    = 64;
	localparam int unsigned OUT_W   = 96;

	localparam logic [9:0] SCALE_X = 10'd640;
	localparam logic [9:0] SCALE_Y = 10'd400;

	localparam logic [POS_W-1:0]  POS_MAX        = 12'd4095;
	localparam logic [POS_W-1:0]  RANGE_LEFT_RST = 12'd0;
	localparam logic [POS_W-1:0]  RANGE_TOP_RST  = 12'd0;
	localparam logic [EDGE_W-1:0] RANGE_RIGHT_RST  = 13'd640;
	localparam logic [EDGE_W-1:0] RANGE_BOTTOM_RST = 13'd480;
	localparam logic [POS_W-1:0]  PTR_RESET_X    = 12'd320;
	localparam logic [POS_W-1:0]  PTR_RESET_Y    = 12'd240;
	localparam logic [GAIN_W-1:0] GAIN_X_RST     = 18'd640;
	localparam logic [GAIN_W-1:0] GAIN_Y_RST     = 18'd400;

	localparam logic [BTN_W-1:0] WHEEL_MASK = 6'b110000;
	localparam logic signed [1:0] WHEEL_UP   = -2'sd1;
	localparam logic signed [1:0] WHEEL_DOWN = 2'sd1;
	localparam logic signed [1:0] WHEEL_NONE = 2'sd0;

	typedef enum logic [CIDX_W-1:0] {
		REG_RANGE_LEFT   = 3'd0,
		REG_RANGE_TOP    = 3'd1,
		REG_RANGE_RIGHT  = 3'd2,
		REG_RANGE_BOTTOM = 3'd3,
		REG_SPEED_X      = 3'd4,
		REG_SPEED_Y      = 3'd5,
		REG_WHEEL_DELAY  = 3'd6
	} cfg_reg_e;

	typedef struct packed {
		logic load_s1;
		logic move_s2;
		logic clamp;
	} pipe_ctrl_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [POS_W-1:0]  lo;
		logic [POS_W-1:0]  hi;
		logic [POS_W-1:0]  clamp_lo;
	} axis_cfg_t;

	typedef struct packed {
		logic signed [STEP_W-1:0] step;
		logic signed [MOVE_W-1:0] moved;
		logic [POS_W-1:0]         pos;
	} lane_out_t;

	typedef struct packed {
		logic signed [1:0]  wheel;
		logic [2:0]         released;
		logic [BTN_W-1:0]   held;
		logic [BTN_W-1:0]   pressed;
	} btn_out_t;

	function automatic logic [POS_W-1:0] clip_pos(
		input logic signed [SUM_W-1:0] v,
		input logic [POS_W-1:0] lo,
		input logic [POS_W-1:0] hi
	);
		logic [POS_W-1:0] r;
		if (v < $signed({3'b000, lo})) begin
			r = lo;
		end else if (v > $signed({3'b000, hi})) begin
			r = hi;
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

	// saturated (edge - 1)
	function automatic logic [POS_W-1:0] upper_bound(input logic [EDGE_W-1:0] edge_v);
		logic [POS_W-1:0] r;
		if (edge_v == '0) begin
			r = '0;
		end else if (edge_v > {1'b0, POS_MAX} + 13'd1) begin
			r = POS_MAX;
		end else begin
			r = 12'(edge_v - 13'd1);
		end
		return r;
	endfunction

	// saturated (start + 1)
	function automatic logic [POS_W-1:0] inner_lower(input logic [POS_W-1:0] start);
		logic [POS_W-1:0] r;
		if (start == POS_MAX) begin
			r = POS_MAX;
		end else begin
			r = start + 12'd1;
		end
		return r;
	endfunction

endpackage

[rtl/core/mpt_axis_lane.sv]
// mpt_axis_lane: one axis lane, scaling, fraction accumulation and pointer clipping
`timescale 1ns / 1ps
module mpt_axis_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mpt_pkg::pipe_ctrl_t            ctrl,
	input  mpt_pkg::axis_cfg_t             cfg,
	input  logic                           axis_y,
	input  logic signed [mpt_pkg::DELTA_W-1:0] delta,
	output mpt_pkg::lane_out_t             res
);

	logic signed [mpt_pkg::PROD_W:0]    mul;
	logic signed [mpt_pkg::PROD_W-1:0]  prod_s1;
	logic [mpt_pkg::POS_W-1:0]          ptr_q;
	logic [mpt_pkg::FRAC_W-1:0]         frac_q;
	logic signed [mpt_pkg::PROD_W:0]    acc;
	logic signed [mpt_pkg::SUM_W-1:0]   step;
	logic signed [mpt_pkg::SUM_W-1:0]   sum;
	logic [mpt_pkg::POS_W-1:0]          ptr_next;
	logic [mpt_pkg::POS_W-1:0]          ptr_clamped;
	logic signed [mpt_pkg::MOVE_W-1:0]  moved;
	mpt_pkg::lane_out_t                 res_s2;

	assign mul = delta * $signed({1'b0, cfg.gain});

	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			prod_s1 <= mul[mpt_pkg::PROD_W-1:0];
		end
	end

	always_comb begin
		acc = $signed({15'b0, frac_q}) + $signed({prod_s1[mpt_pkg::PROD_W-1], prod_s1});
		step = $signed(acc[mpt_pkg::PROD_W:mpt_pkg::FRAC_W]);
		sum = $signed({3'b000, ptr_q}) + step;
		ptr_next = mpt_pkg::clip_pos(sum, cfg.lo, cfg.hi);
		moved = $signed({1'b0, ptr_next}) - $signed({1'b0, ptr_q});
		ptr_clamped = mpt_pkg::clip_pos($signed({3'b000, ptr_q}), cfg.clamp_lo, cfg.hi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= axis_y ? mpt_pkg::PTR_RESET_Y : mpt_pkg::PTR_RESET_X;
			frac_q <= '0;
		end else if (ctrl.clamp) begin
			ptr_q  <= ptr_clamped;
			frac_q <= '0;
		end else if (ctrl.move_s2) begin
			ptr_q  <= ptr_next;
			frac_q <= acc[mpt_pkg::FRAC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.move_s2) begin
			res_s2.pos   <= ptr_next;
			res_s2.moved <= moved;
			res_s2.step  <= step[mpt_pkg::STEP_W-1:0];
		end
	end

	assign res = res_s2;

endmodule

[rtl/core/mpt_button_unit.sv]
// mpt_button_unit: wheel rate limiting and button press and release edges
`timescale 1ns / 1ps
module mpt_button_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mpt_pkg::pipe_ctrl_t           ctrl,
	input  logic [mpt_pkg::DELAY_W-1:0]   wheel_delay,
	input  logic [mpt_pkg::BTN_W-1:0]     buttons,
	input  logic [mpt_pkg::TICK_W-1:0]    now,
	output mpt_pkg::btn_out_t             res
);

	logic [mpt_pkg::BTN_W-1:0]  btn_s1;
	logic [mpt_pkg::TICK_W-1:0] now_s1;
	logic [mpt_pkg::BTN_W-1:0]  held_q;
	logic [mpt_pkg::TICK_W-1:0] deadline_q;
	logic                       has_wheel;
	logic                       suppress;
	logic                       take_wheel;
	logic [mpt_pkg::BTN_W-1:0]  btn_eff;
	logic signed [1:0]          wheel;
	mpt_pkg::btn_out_t          res_s2;

	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			btn_s1 <= buttons;
			now_s1 <= now;
		end
	end

	always_comb begin
		has_wheel  = |(btn_s1 & mpt_pkg::WHEEL_MASK);
		suppress   = has_wheel && (wheel_delay != '0) && (now_s1 <= deadline_q);
		take_wheel = has_wheel && !suppress;
		btn_eff    = suppress ? (btn_s1 & ~mpt_pkg::WHEEL_MASK) : btn_s1;
		if (!take_wheel) begin
			wheel = mpt_pkg::WHEEL_NONE;
		end else if (btn_s1[4]) begin
			wheel = mpt_pkg::WHEEL_UP;
		end else begin
			wheel = mpt_pkg::WHEEL_DOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			deadline_q <= '0;
		end else if (ctrl.move_s2) begin
			held_q <= btn_eff;
			if (take_wheel) begin
				deadline_q <= now_s1 + {16'b0, wheel_delay};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.move_s2) begin
			res_s2.wheel    <= wheel;
			res_s2.released <= held_q[2:0] & ~btn_eff[2:0];
			res_s2.held     <= btn_eff;
			res_s2.pressed  <= ~held_q & btn_eff;
		end
	end

	assign res = res_s2;

endmodule

[rtl/core/mouse_pointer_tracker_top.sv]
// mouse_pointer_tracker_top: mouse poll tracker with one lane per axis and a merged result
//
// usage
//   s_tvalid/s_tready/s_tdata carries one poll item, m_tvalid/m_tready/m_tdata one result
//   per item; cfg_valid/cfg_ready/cfg_index/cfg_data writes the registers, cfg_ready is
//   always high and a range write clamps the pointer in the cycle after the write
// timing
//   stage 1 registers the delta times speed product of each axis lane, stage 2 closes
//   the fraction, pointer and button state loop and registers the result;
//   throughput is one item per cycle while m_tready is high, set by that state loop
// reset
//   arst_n clears both stages, sets the range to 640 by 480, the pointer to the
//   centre, speeds to 1 and clears fractions, held buttons and the wheel deadline
// stall
//   while m_tready is low the result holds; stage 1 still takes one more item,
//   after which s_tready drops until the result is taken
`timescale 1ns / 1ps
module mouse_pointer_tracker_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mpt_pkg::IN_W-1:0]      s_tdata,   // raw_dx, raw_dy, raw_buttons, now, pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mpt_pkg::OUT_W-1:0]     m_tdata,   // pos_x, pos_y, moved_x, moved_y, step_x,
	                                                 // step_y, pressed, held, released, wheel, pad
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mpt_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [mpt_pkg::CDATA_W-1:0]   cfg_data
);

	logic [mpt_pkg::POS_W-1:0]   range_left_q;
	logic [mpt_pkg::POS_W-1:0]   range_top_q;
	logic [mpt_pkg::EDGE_W-1:0]  range_right_q;
	logic [mpt_pkg::EDGE_W-1:0]  range_bottom_q;
	logic [mpt_pkg::GAIN_W-1:0]  gain_x_q;
	logic [mpt_pkg::GAIN_W-1:0]  gain_y_q;
	logic [mpt_pkg::DELAY_W-1:0] wheel_delay_q;
	logic                        apply_q;
	logic                        valid_s1;
	logic                        valid_s2;
	logic                        adv_s2;
	logic                        cfg_wr;
	mpt_pkg::pipe_ctrl_t         ctrl;
	mpt_pkg::axis_cfg_t          cfg_x;
	mpt_pkg::axis_cfg_t          cfg_y;
	mpt_pkg::lane_out_t          res_x;
	mpt_pkg::lane_out_t          res_y;
	mpt_pkg::btn_out_t           res_b;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_left_q   <= mpt_pkg::RANGE_LEFT_RST;
			range_top_q    <= mpt_pkg::RANGE_TOP_RST;
			range_right_q  <= mpt_pkg::RANGE_RIGHT_RST;
			range_bottom_q <= mpt_pkg::RANGE_BOTTOM_RST;
			gain_x_q       <= mpt_pkg::GAIN_X_RST;
			gain_y_q       <= mpt_pkg::GAIN_Y_RST;
			wheel_delay_q  <= '0;
			apply_q        <= 1'b0;
		end else begin
			apply_q <= 1'b0;
			if (cfg_wr) begin
				unique case (cfg_index)
					mpt_pkg::REG_RANGE_LEFT: begin
						range_left_q <= cfg_data[mpt_pkg::POS_W-1:0];
						apply_q      <= 1'b1;
					end
					mpt_pkg::REG_RANGE_TOP: begin
						range_top_q <= cfg_data[mpt_pkg::POS_W-1:0];
						apply_q     <= 1'b1;
					end
					mpt_pkg::REG_RANGE_RIGHT: begin
						range_right_q <= cfg_data[mpt_pkg::EDGE_W-1:0];
						apply_q       <= 1'b1;
					end
					mpt_pkg::REG_RANGE_BOTTOM: begin
						range_bottom_q <= cfg_data[mpt_pkg::EDGE_W-1:0];
						apply_q        <= 1'b1;
					end
					mpt_pkg::REG_SPEED_X: begin
						gain_x_q <= 18'(cfg_data[7:0]) * 18'(mpt_pkg::SCALE_X);
					end
					mpt_pkg::REG_SPEED_Y: begin
						gain_y_q <= 18'(cfg_data[7:0]) * 18'(mpt_pkg::SCALE_Y);
					end
					mpt_pkg::REG_WHEEL_DELAY: begin
						wheel_delay_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// two-stage flow control, stage 1 refills while the result waits
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;

	always_comb begin
		ctrl.load_s1 = s_tvalid && s_tready;
		ctrl.move_s2 = valid_s1 && adv_s2;
		ctrl.clamp   = apply_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.load_s1 || (valid_s1 && !ctrl.move_s2);
			valid_s2 <= ctrl.move_s2 || (valid_s2 && !m_tready);
		end
	end

	always_comb begin
		cfg_x.gain     = gain_x_q;
		cfg_x.lo       = range_left_q;
		cfg_x.hi       = mpt_pkg::upper_bound(range_right_q);
		cfg_x.clamp_lo = mpt_pkg::inner_lower(range_left_q);
		cfg_y.gain     = gain_y_q;
		cfg_y.lo       = range_top_q;
		cfg_y.hi       = mpt_pkg::upper_bound(range_bottom_q);
		cfg_y.clamp_lo = mpt_pkg::inner_lower(range_top_q);
	end

	mpt_axis_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cfg    (cfg_x),
		.axis_y (1'b0),
		.delta  ($signed(s_tdata[11:0])),
		.res    (res_x)
	);

	mpt_axis_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cfg    (cfg_y),
		.axis_y (1'b1),
		.delta  ($signed(s_tdata[23:12])),
		.res    (res_y)
	);

	mpt_button_unit u_buttons (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.wheel_delay (wheel_delay_q),
		.buttons     (s_tdata[29:24]),
		.now         (s_tdata[61:30]),
		.res         (res_b)
	);

	// merge lanes into one result item
	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_b.wheel, res_b.released, res_b.held, res_b.pressed,
		res_y.step, res_x.step, res_y.moved, res_x.moved, res_y.pos, res_x.pos};

`ifndef NO_ASSERTIONS
	a_s2_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result stage filled without an item in stage 1");

	a_pressed_in_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((res_b.pressed & ~res_b.held) == '0))
		else $error("pressed bit outside held buttons");

	a_released_not_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((res_b.released & res_b.held[2:0]) == '0))
		else $error("released button still held");

	a_wheel_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_b.wheel != 2'b10))
		else $error("invalid wheel code");
`endif

endmodule

[tb/sv/mouse_pointer_tracker_top_tb.sv]
// mouse_pointer_tracker_top_tb: random and directed polls against an in-bench pointer predictor
`timescale 1ns / 1ps
module mouse_pointer_tracker_top_tb;
	import mpt_pkg::*;

	localparam logic [CIDX_W-1:0] REG_UNUSED  = 3'd7;
	localparam logic [BTN_W-1:0]  BUTTON_MASK = 6'b000111;
	localparam int WHEEL_UP_BIT      = 4;
	localparam int DRAIN_CYCLES      = 4;
	localparam int SEGMENTS          = 12;
	localparam int POLLS_PER_SEGMENT = 160;

	typedef struct packed {
		logic [1:0]                pad;
		logic [TICK_W-1:0]         now;
		logic [BTN_W-1:0]          buttons;
		logic signed [DELTA_W-1:0] dy;
		logic signed [DELTA_W-1:0] dx;
	} poll_t;

	typedef struct packed {
		logic                     pad;
		logic signed [1:0]        wheel;
		logic [2:0]               released;
		logic [BTN_W-1:0]         held;
		logic [BTN_W-1:0]         pressed;
		logic signed [STEP_W-1:0] step_y;
		logic signed [STEP_W-1:0] step_x;
		logic signed [MOVE_W-1:0] moved_y;
		logic signed [MOVE_W-1:0] moved_x;
		logic [POS_W-1:0]         pos_y;
		logic [POS_W-1:0]         pos_x;
	} result_t;

	class poll_checker;
		logic [POS_W-1:0]   edge_left, edge_top;
		logic [EDGE_W-1:0]  edge_right, edge_bottom;
		logic [7:0]         gain_x, gain_y;
		logic [DELAY_W-1:0] wheel_delay;
		int                 cur_x, cur_y;
		logic [FRAC_W-1:0]  frac_x, frac_y;
		logic [BTN_W-1:0]   prev_buttons;
		logic [TICK_W-1:0]  wheel_until;
		result_t            due_results[$];
		int                 errors;
		int                 checked;

		function new();
			errors = 0;
			checked = 0;
			edge_left = RANGE_LEFT_RST;
			edge_top = RANGE_TOP_RST;
			edge_right = RANGE_RIGHT_RST;
			edge_bottom = RANGE_BOTTOM_RST;
			gain_x = 8'd1;
			gain_y = 8'd1;
			wheel_delay = '0;
			frac_x = '0;
			frac_y = '0;
			prev_buttons = '0;
			wheel_until = '0;
			cur_x = (int'(edge_right) - int'(edge_left)) >>> 1;
			cur_y = (int'(edge_bottom) - int'(edge_top)) >>> 1;
		endfunction

		function int clip(longint v, longint lo, longint hi);
			if (lo < 0) lo = 0;
			if (lo > longint'(POS_MAX)) lo = longint'(POS_MAX);
			if (hi < 0) hi = 0;
			if (hi > longint'(POS_MAX)) hi = longint'(POS_MAX);
			if (v < lo) return int'(lo);
			if (v > hi) return int'(hi);
			return int'(v);
		endfunction

		// fraction plus scaled delta, the caller splits step and fraction
		function longint accumulate(logic [FRAC_W-1:0] frac, logic signed [DELTA_W-1:0] d,
				logic [7:0] gain, longint scale);
			return longint'(frac) + longint'(d) * longint'(gain) * scale;
		endfunction

		function void clamp_inside();
			frac_x = '0;
			frac_y = '0;
			cur_x = clip(cur_x, longint'(edge_left) + 1, longint'(edge_right) - 1);
			cur_y = clip(cur_y, longint'(edge_top) + 1, longint'(edge_bottom) - 1);
		endfunction

		function void set_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
			case (idx)
				REG_RANGE_LEFT: begin
					edge_left = data[POS_W-1:0];
					clamp_inside();
				end
				REG_RANGE_TOP: begin
					edge_top = data[POS_W-1:0];
					clamp_inside();
				end
				REG_RANGE_RIGHT: begin
					edge_right = data[EDGE_W-1:0];
					clamp_inside();
				end
				REG_RANGE_BOTTOM: begin
					edge_bottom = data[EDGE_W-1:0];
					clamp_inside();
				end
				REG_SPEED_X: gain_x = data[7:0];
				REG_SPEED_Y: gain_y = data[7:0];
				REG_WHEEL_DELAY: wheel_delay = data[DELAY_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_poll(poll_t p);
			result_t r;
			logic [BTN_W-1:0] btn;
			longint acc_x, acc_y, sx, sy;
			int old_x, old_y;
			r = '0;
			btn = p.buttons;
			r.wheel = WHEEL_NONE;
			if ((btn & WHEEL_MASK) != '0) begin
				if (wheel_delay != '0 && p.now <= wheel_until) begin
					btn = btn & ~WHEEL_MASK;
				end else begin
					r.wheel = btn[WHEEL_UP_BIT] ? WHEEL_UP : WHEEL_DOWN;
					wheel_until = p.now + TICK_W'(wheel_delay);
				end
			end
			r.released = 3'(prev_buttons & ~btn & BUTTON_MASK);
			r.pressed = ~prev_buttons & btn;
			r.held = btn;
			prev_buttons = btn;

			acc_x = accumulate(frac_x, p.dx, gain_x, longint'(SCALE_X));
			acc_y = accumulate(frac_y, p.dy, gain_y, longint'(SCALE_Y));
			frac_x = acc_x[FRAC_W-1:0];
			frac_y = acc_y[FRAC_W-1:0];
			sx = acc_x >>> FRAC_W;
			sy = acc_y >>> FRAC_W;

			old_x = cur_x;
			old_y = cur_y;
			cur_x = clip(cur_x + sx, longint'(edge_left), longint'(edge_right) - 1);
			cur_y = clip(cur_y + sy, longint'(edge_top), longint'(edge_bottom) - 1);
			r.pos_x = POS_W'(cur_x);
			r.pos_y = POS_W'(cur_y);
			r.moved_x = MOVE_W'(cur_x - old_x);
			r.moved_y = MOVE_W'(cur_y - old_y);
			r.step_x = STEP_W'(sx);
			r.step_y = STEP_W'(sy);
			due_results.push_back(r);
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40) $display("mismatch %0d: %s", errors, what);
		endtask

		task compare_field(string field, logic [15:0] got, logic [15:0] want);
			if (got !== want) report($sformatf("%s got %0h want %0h", field, got, want));
		endtask

		task match_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("result %h with nothing pending", got));
			end else begin
				want = due_results.pop_front();
				checked++;
				compare_field("pos_x", got.pos_x, want.pos_x);
				compare_field("pos_y", got.pos_y, want.pos_y);
				compare_field("moved_x", got.moved_x, want.moved_x);
				compare_field("moved_y", got.moved_y, want.moved_y);
				compare_field("step_x", got.step_x, want.step_x);
				compare_field("step_y", got.step_y, want.step_y);
				compare_field("pressed", got.pressed, want.pressed);
				compare_field("held", got.held, want.held);
				compare_field("released", got.released, want.released);
				compare_field("wheel", got.wheel, want.wheel);
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index = '0;
	logic [CDATA_W-1:0] cfg_data = '0;

	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          polls_sent = 0;
	int          settings_used = 0;
	logic [31:0] tick = '0;
	poll_checker tracker;

	mouse_pointer_tracker_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) tracker.match_result(result_t'(m_tdata));
	end

	// each idle cycle before an item is drawn on its own
	task automatic send_poll(poll_t p);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= p;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		tracker.take_poll(p);
		polls_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_setting(logic [15:0] l, logic [15:0] t, logic [15:0] r,
			logic [15:0] b, logic [15:0] sx, logic [15:0] sy, logic [15:0] wd);
		write_reg(REG_RANGE_LEFT, l);
		write_reg(REG_RANGE_TOP, t);
		write_reg(REG_RANGE_RIGHT, r);
		write_reg(REG_RANGE_BOTTOM, b);
		write_reg(REG_SPEED_X, sx);
		write_reg(REG_SPEED_Y, sy);
		write_reg(REG_WHEEL_DELAY, wd);
		settings_used++;
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic poll_t poll_of(int dx, int dy, int btn, logic [31:0] now);
		poll_t p;
		p.pad = '0;
		p.dx = DELTA_W'(dx);
		p.dy = DELTA_W'(dy);
		p.buttons = BTN_W'(btn);
		p.now = now;
		return p;
	endfunction

	function automatic logic [DELTA_W-1:0] random_delta();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) return DELTA_W'(int'($urandom_range(0, 16)) - 8);
		if (pick < 90) return DELTA_W'($urandom);
		return $urandom_range(0, 1) ? 12'h7FF : 12'h800;
	endfunction

	function automatic poll_t make_poll();
		poll_t p;
		int pick;
		p.pad = '0;
		p.dx = random_delta();
		p.dy = random_delta();
		if ($urandom_range(0, 99) < 60) begin
			p.buttons = {($urandom_range(0, 99) < 25) ? 2'($urandom_range(1, 3)) : 2'b00,
				1'b0, 3'($urandom)};
		end else begin
			p.buttons = BTN_W'($urandom);
		end
		// mostly a slowly rising tick so the wheel window gets hit
		pick = $urandom_range(0, 99);
		if (pick < 95) tick = tick + $urandom_range(0, 12);
		else if (pick < 98) tick = $urandom;
		else tick = 32'hFFFF_FFFF - $urandom_range(0, 20);
		p.now = tick;
		return p;
	endfunction

	function automatic logic [15:0] random_start();
		if ($urandom_range(0, 99) < 70) return 16'($urandom_range(0, 400));
		return 16'($urandom_range(0, 4095));
	endfunction

	function automatic logic [15:0] random_end(logic [15:0] s);
		if ($urandom_range(0, 99) < 80) return s + 16'($urandom_range(1, 800));
		return 16'($urandom_range(0, 8191));
	endfunction

	function automatic logic [15:0] random_gain();
		if ($urandom_range(0, 99) < 50) return 16'($urandom_range(0, 4));
		return 16'($urandom_range(0, 255));
	endfunction

	task automatic pick_setting(int seg);
		logic [15:0] l, t, r, b, wd;
		int pick;
		if (seg == 0) begin
			load_setting(0, 0, 8191, 8191, 255, 255, 65535);
		end else if (seg == 1) begin
			load_setting(4095, 4095, 0, 0, 0, 0, 0);
		end else begin
			l = random_start();
			t = random_start();
			r = random_end(l);
			b = random_end(t);
			pick = $urandom_range(0, 99);
			if (pick < 70) wd = 16'($urandom_range(1, 40));
			else if (pick < 85) wd = '0;
			else wd = 16'($urandom);
			load_setting(l, t, r, b, random_gain(), random_gain(), wd);
		end
	endtask

	initial begin
		tracker = new();
		tx_idle_pct = 30;
		rx_idle_pct = 50;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset setting: field extremes, every button bit and every wheel pattern
		send_poll(poll_of(0, 0, 0, 0));
		send_poll(poll_of(2047, 2047, 7, 1));
		send_poll(poll_of(-2048, -2048, 0, 2));
		send_poll(poll_of(1, -1, 16, 3));
		send_poll(poll_of(0, 0, 32, 4));
		send_poll(poll_of(0, 0, 48, 5));
		send_poll(poll_of(0, 0, 63, 6));
		send_poll(poll_of(-1, 1, 8, 32'hFFFF_FFFF));
		send_poll(poll_of(2047, -2048, 0, 0));

		// wheel window, including the deadline tick itself
		wait_idle();
		load_setting(0, 0, 640, 480, 255, 200, 10);
		send_poll(poll_of(0, 0, 16, 100));
		send_poll(poll_of(0, 0, 32, 105));
		send_poll(poll_of(0, 0, 16, 110));
		send_poll(poll_of(0, 0, 48, 111));
		send_poll(poll_of(2047, 2047, 7, 200));
		send_poll(poll_of(-2048, -2048, 0, 201));

		// inverted range and an unknown register
		wait_idle();
		write_reg(REG_UNUSED, 16'hFFFF);
		load_setting(100, 50, 90, 40, 3, 3, 65535);
		send_poll(poll_of(3, 3, 16, 0));
		send_poll(poll_of(-3, -3, 1, 0));
		send_poll(poll_of(0, 0, 48, 32'hFFFF_FFFF));

		// range at the far corner
		wait_idle();
		load_setting(4095, 4095, 4096, 4096, 255, 255, 1);
		send_poll(poll_of(2047, 2047, 0, 5));
		send_poll(poll_of(-2048, -2048, 0, 6));

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_idle();
			if (seg < SEGMENTS / 3) begin
				tx_idle_pct = 30;
				rx_idle_pct = 50;
			end else if (seg < 2 * SEGMENTS / 3) begin
				tx_idle_pct = 50;
				rx_idle_pct = 30;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			pick_setting(seg);
			for (int n = 0; n < POLLS_PER_SEGMENT; n++) begin
				if (n == POLLS_PER_SEGMENT / 2) wait_idle();
				send_poll(make_poll());
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (tracker.due_results.size() != 0)
			tracker.report($sformatf("%0d results never arrived", tracker.due_results.size()));
		$display("covered %0d polls over %0d register settings, %0d results checked",
			polls_sent, settings_used, tracker.checked);
		$display("stalls on both sides in two mixes, then back-to-back streaming");
		if (tracker.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout waiting on the block");
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
